// ----- hw/rtl/first_fit_aligned_segment_allocator_core_assert.svh -----
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_ALIGNED_SEGMENT_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_ALIGNED_SEGMENT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FFAS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FFAS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ffas_pkg.sv -----
// Package: sizes, command codes and transaction types of the segment allocator.
package ffas_pkg;

	localparam int SEG_ENTRIES = 64;
	localparam int ADDR_BITS   = 48;
	localparam int FIELD_W     = 48;
	localparam int INDEX_W     = 6;
	localparam int ALIGN_W     = 5;
	localparam int LIVE_W      = 7;
	localparam int IDX_W       = $clog2(SEG_ENTRIES);
	localparam int PAD_W       = 2 ** ALIGN_W - 1;
	localparam int ALU_W       = FIELD_W + 1;

	localparam logic [FIELD_W-1:0] ADDR_MASK = (ADDR_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
		FIELD_W'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef struct packed {
		logic               command;
		logic [INDEX_W-1:0] entry_index;
		logic [FIELD_W-1:0] entry_base;
		logic [FIELD_W-1:0] entry_size;
		logic [FIELD_W-1:0] request_size;
		logic [ALIGN_W-1:0] align_log2;
	} ffas_in_t;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] block_address;
		logic [LIVE_W-1:0]  live_entries;
	} ffas_out_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} ffas_alu_op_t;

	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_idx;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_idx;
		logic [FIELD_W-1:0] wr_base;
		logic [FIELD_W-1:0] wr_size;
		logic               wr_valid;
		logic [IDX_W-1:0]   look_idx;
	} ffas_tbl_ctl_t;

endpackage

// ----- hw/rtl/ffas_alu.sv -----
// Shared add/subtract unit; the top bit is carry on add and borrow on subtract.
module ffas_alu
	import ffas_pkg::*;
(
	input  ffas_alu_op_t     op,
	output logic [ALU_W-1:0] res
);

	// Operands stay below 2^FIELD_W, so the msb is a clean carry/borrow flag.
	always_comb begin
		if (op.sub) begin
			res = op.a - op.b;
		end else begin
			res = op.a + op.b;
		end
	end

endmodule

// ----- hw/rtl/ffas_table.sv -----
// Segment table: base and size memories with registered read, plus per-entry valid flags.
module ffas_table
	import ffas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ffas_tbl_ctl_t      ctl,
	output logic [FIELD_W-1:0] rd_base,
	output logic [FIELD_W-1:0] rd_size,
	output logic               look_valid
);

	logic [FIELD_W-1:0]     base_mem [SEG_ENTRIES];
	logic [FIELD_W-1:0]     size_mem [SEG_ENTRIES];
	logic [FIELD_W-1:0]     rd_base_q;
	logic [FIELD_W-1:0]     rd_size_q;
	logic [SEG_ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			base_mem[ctl.wr_idx] <= ctl.wr_base;
			size_mem[ctl.wr_idx] <= ctl.wr_size;
		end
		if (ctl.rd_en) begin
			rd_base_q <= base_mem[ctl.rd_idx];
			rd_size_q <= size_mem[ctl.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_idx] <= ctl.wr_valid;
		end
	end

	assign rd_base    = rd_base_q;
	assign rd_size    = rd_size_q;
	assign look_valid = valid_q[ctl.look_idx];

endmodule

// ----- hw/rtl/ffas_ctrl.sv -----
// Sequencer: load and first-fit walk, driving the shared adder and the segment table.
module ffas_ctrl
	import ffas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffas_in_t           req,
	output logic               busy,
	output logic               done,
	output ffas_out_t          rsp,
	output ffas_alu_op_t       alu_op,
	input  logic [ALU_W-1:0]   alu_res,
	output ffas_tbl_ctl_t      tbl_ctl,
	input  logic [FIELD_W-1:0] rd_base,
	input  logic [FIELD_W-1:0] rd_size,
	input  logic               look_valid
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_PAD,
		ST_SUB1,
		ST_SUB2,
		ST_ADD1,
		ST_ADD2,
		ST_NOFIT
	} state_t;

	state_t             state_q;
	ffas_in_t           req_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PAD_W-1:0]   amask_q;
	logic [PAD_W-1:0]   pad_q;
	logic [ALU_W-1:0]   left_q;
	logic [FIELD_W-1:0] aligned_q;
	logic [LIVE_W-1:0]  live_q;
	logic               done_q;
	logic               ok_q;
	logic [FIELD_W-1:0] addr_q;
	logic [LIVE_W-1:0]  live_out_q;

	logic               idx_ok;
	logic               last_entry;
	logic               load_valid;
	logic               left_zero;
	logic               add1_ovf;
	logic [LIVE_W-1:0]  live_load;
	logic [FIELD_W-1:0] pad_ext;

	assign idx_ok     = 32'(req_q.entry_index) < SEG_ENTRIES;
	assign last_entry = idx_q == IDX_W'(SEG_ENTRIES - 1);
	assign load_valid = |req_q.entry_size;
	assign left_zero  = left_q[FIELD_W-1:0] == '0;
	assign add1_ovf   = alu_res[ALU_W-1] || ((alu_res[FIELD_W-1:0] & ~ADDR_MASK) != '0);
	assign pad_ext    = FIELD_W'(pad_q);

	always_comb begin
		live_load = live_q;
		if (idx_ok) begin
			if (look_valid && !load_valid) begin
				live_load = live_q - 1'b1;
			end else if (!look_valid && load_valid) begin
				live_load = live_q + 1'b1;
			end
		end
	end

	// Operand select for the shared adder
	always_comb begin
		alu_op = '0;
		unique case (state_q)
			ST_SUB1: begin
				alu_op.a   = {1'b0, rd_size};
				alu_op.b   = {1'b0, pad_ext};
				alu_op.sub = 1'b1;
			end
			ST_SUB2: begin
				alu_op.a   = left_q;
				alu_op.b   = {1'b0, req_q.request_size};
				alu_op.sub = 1'b1;
			end
			ST_ADD1: begin
				alu_op.a = {1'b0, rd_base};
				alu_op.b = {1'b0, pad_ext};
			end
			ST_ADD2: begin
				alu_op.a = {1'b0, aligned_q};
				alu_op.b = {1'b0, req_q.request_size};
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	always_comb begin
		tbl_ctl          = '0;
		tbl_ctl.rd_idx   = idx_q;
		tbl_ctl.look_idx = idx_q;
		unique case (state_q)
			ST_LOAD: begin
				tbl_ctl.look_idx = req_q.entry_index[IDX_W-1:0];
				tbl_ctl.wr_en    = idx_ok;
				tbl_ctl.wr_idx   = req_q.entry_index[IDX_W-1:0];
				tbl_ctl.wr_base  = req_q.entry_base & ADDR_MASK;
				tbl_ctl.wr_size  = req_q.entry_size;
				tbl_ctl.wr_valid = load_valid;
			end
			ST_SCAN: begin
				tbl_ctl.rd_en = look_valid;
			end
			ST_ADD2: begin
				tbl_ctl.wr_en    = 1'b1;
				tbl_ctl.wr_idx   = idx_q;
				tbl_ctl.wr_base  = alu_res[FIELD_W-1:0] & ADDR_MASK;
				tbl_ctl.wr_size  = left_q[FIELD_W-1:0];
				tbl_ctl.wr_valid = !left_zero;
			end
			default: begin
				tbl_ctl.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			live_q     <= '0;
			done_q     <= 1'b0;
			idx_q      <= '0;
			ok_q       <= 1'b0;
			addr_q     <= '0;
			live_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						amask_q <= (PAD_W'(1) << req.align_log2) - 1'b1;
						idx_q   <= '0;
						if (req.command == CMD_LOAD) begin
							state_q <= ST_LOAD;
						end else if (req.request_size == '0) begin
							state_q <= ST_NOFIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_LOAD: begin
					live_q     <= live_load;
					done_q     <= 1'b1;
					ok_q       <= idx_ok;
					addr_q     <= '0;
					live_out_q <= live_load;
					state_q    <= ST_IDLE;
				end
				ST_SCAN: begin
					if (look_valid) begin
						state_q <= ST_PAD;
					end else if (last_entry) begin
						state_q <= ST_NOFIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PAD: begin
					// distance from base up to the next aligned address
					pad_q   <= (PAD_W'(0) - rd_base[PAD_W-1:0]) & amask_q;
					state_q <= ST_SUB1;
				end
				ST_SUB1: begin
					left_q <= alu_res;
					if (!alu_res[ALU_W-1]) begin
						state_q <= ST_SUB2;
					end else if (last_entry) begin
						state_q <= ST_NOFIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SUB2: begin
					left_q <= alu_res;
					if (!alu_res[ALU_W-1]) begin
						state_q <= ST_ADD1;
					end else if (last_entry) begin
						state_q <= ST_NOFIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_ADD1: begin
					aligned_q <= alu_res[FIELD_W-1:0];
					if (!add1_ovf) begin
						state_q <= ST_ADD2;
					end else if (last_entry) begin
						state_q <= ST_NOFIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_ADD2: begin
					if (left_zero) begin
						live_q     <= live_q - 1'b1;
						live_out_q <= live_q - 1'b1;
					end else begin
						live_out_q <= live_q;
					end
					done_q  <= 1'b1;
					ok_q    <= 1'b1;
					addr_q  <= aligned_q;
					state_q <= ST_IDLE;
				end
				ST_NOFIT: begin
					done_q     <= 1'b1;
					ok_q       <= 1'b0;
					addr_q     <= '0;
					live_out_q <= live_q;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy              = state_q != ST_IDLE;
	assign done              = done_q;
	assign rsp.ok            = ok_q;
	assign rsp.block_address = addr_q;
	assign rsp.live_entries  = live_out_q;

endmodule

// ----- hw/rtl/first_fit_aligned_segment_allocator_core.sv -----
// Top level of the first-fit aligned segment allocator.
// A command is taken when start is high and busy is low; its single result
// shows on rsp for one cycle with done high, and must be captured then, since
// the block cannot be held off. A load writes one table entry in the load state.
// An allocate walks the 64-entry table in index order through one shared
// 49-bit adder: invalid entries are skipped in the scan state; a valid entry
// has its pad worked out, then the pad and the request are taken from its size
// and the pad added to its base, and it is left at the first step that fails;
// the entry that fits gets its new base and size written back. A request of
// zero bytes fails without a walk. Busy is high until the result shows.
module first_fit_aligned_segment_allocator_core
	import ffas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ffas_in_t  req,
	output logic      busy,
	output logic      done,
	output ffas_out_t rsp
);

	ffas_alu_op_t       alu_op;
	logic [ALU_W-1:0]   alu_res;
	ffas_tbl_ctl_t      tbl_ctl;
	logic [FIELD_W-1:0] rd_base;
	logic [FIELD_W-1:0] rd_size;
	logic               look_valid;

	ffas_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	ffas_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tbl_ctl),
		.rd_base    (rd_base),
		.rd_size    (rd_size),
		.look_valid (look_valid)
	);

	ffas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp),
		.alu_op     (alu_op),
		.alu_res    (alu_res),
		.tbl_ctl    (tbl_ctl),
		.rd_base    (rd_base),
		.rd_size    (rd_size),
		.look_valid (look_valid)
	);

endmodule

// ----- hw/rtl/ffas_check.sv -----
// Port-level checker for the allocator, bound to the top level.
`include "first_fit_aligned_segment_allocator_core_assert.svh"

module ffas_check
	import ffas_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input ffas_out_t rsp
);

	`FFAS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	`FFAS_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
	`FFAS_ASSERT_NXT(a_one_result, done, !done, "result strobe held two cycles")
	`FFAS_ASSERT_IMP(a_busy_end, $fell(busy), done, "busy dropped without a result")
	`FFAS_ASSERT_IMP(a_fail_zero, done && !rsp.ok, rsp.block_address == '0,
		"failed transaction returned a nonzero address")

endmodule

bind first_fit_aligned_segment_allocator_core ffas_check u_ffas_check (.*);
